[rtl/lsm_pkg.sv]
package lsm_pkg;

    typedef enum logic [1:0] {
        DISP_WRITTEN   = 2'd0,
        DISP_DUPLICATE = 2'd1,
        DISP_DROPPED   = 2'd2
    } disp_t;

    localparam logic CFG_ACTIVE_STREAMS = 1'b0;
    localparam logic CFG_TOMB_DROP      = 1'b1;
    localparam int RES_LIMIT = 8;

    // controller to datapath
    typedef struct packed {
        logic load;      // write the input entry into its head slot
        logic scan_clr;  // start a new minimum scan
        logic scan_step; // compare one head against the running best
        logic pop;       // emit the best head into the output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic best_last;
        logic any_left;  // some head other than the best is present
    } dp_status_t;

endpackage

[rtl/lsm_datapath.sv]
module lsm_datapath #(
    parameter int MAX_STREAMS = 8,
    parameter int KEY_BITS    = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lsm_pkg::dp_cmd_t                cmd,
    input  logic [$clog2(MAX_STREAMS)-1:0]  load_idx,
    input  logic [$clog2(MAX_STREAMS)-1:0]  scan_idx,
    input  logic [63:0]                     in_key,
    input  logic [63:0]                     in_value,
    input  logic                            in_tomb,
    input  logic                            in_last,
    input  logic                            drop_tomb,
    output lsm_pkg::dp_status_t             status,
    output logic [MAX_STREAMS-1:0]          present,
    output logic [$clog2(MAX_STREAMS)-1:0]  best_idx,
    output logic [63:0]                     pop_key,
    output logic [63:0]                     pop_value,
    output logic [1:0]                      pop_disp
);
    localparam int IW = $clog2(MAX_STREAMS);

    logic [KEY_BITS-1:0]    key_mem   [MAX_STREAMS];
    logic [63:0]            value_mem [MAX_STREAMS];
    logic [MAX_STREAMS-1:0] tomb_reg;
    logic [MAX_STREAMS-1:0] last_reg;
    logic [MAX_STREAMS-1:0] present_reg;
    logic [KEY_BITS-1:0]    best_key_reg;
    logic [IW-1:0]          best_idx_reg;
    logic                   best_found_reg;
    logic [KEY_BITS-1:0]    prev_key_reg;
    logic                   prev_valid_reg;
    logic [63:0]            pop_key_reg;
    logic [63:0]            pop_value_reg;
    logic [1:0]             pop_disp_reg;
    logic                   take;
    logic                   dup;
    logic [MAX_STREAMS-1:0] others;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_mem[load_idx]   <= in_key[KEY_BITS-1:0];
            value_mem[load_idx] <= in_value;
            tomb_reg[load_idx]  <= in_tomb;
            last_reg[load_idx]  <= in_last;
        end
    end

    // one head per step, strict less keeps the lower stream on ties
    assign take = present_reg[scan_idx]
               && (!best_found_reg || key_mem[scan_idx] < best_key_reg);
    assign dup  = prev_valid_reg && (best_key_reg == prev_key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            best_found_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            best_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
                present_reg[load_idx] <= 1'b1;
            if (cmd.scan_clr)
                best_found_reg <= 1'b0;
            else if (cmd.scan_step && take)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= scan_idx;
            end
            if (cmd.pop)
            begin
                present_reg[best_idx_reg] <= 1'b0;
                if (!dup)
                    prev_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && take)
            best_key_reg <= key_mem[scan_idx];
        if (cmd.pop)
        begin
            pop_key_reg   <= 64'(best_key_reg);
            pop_value_reg <= value_mem[best_idx_reg];
            if (dup)
                pop_disp_reg <= lsm_pkg::DISP_DUPLICATE;
            else
            begin
                prev_key_reg <= best_key_reg;
                pop_disp_reg <= (drop_tomb && tomb_reg[best_idx_reg])
                              ? lsm_pkg::DISP_DROPPED : lsm_pkg::DISP_WRITTEN;
            end
        end
    end

    always_comb
    begin
        others = present_reg;
        others[best_idx_reg] = 1'b0;
    end

    assign status.best_last  = last_reg[best_idx_reg];
    assign status.any_left   = |others;
    assign present   = present_reg;
    assign best_idx  = best_idx_reg;
    assign pop_key   = pop_key_reg;
    assign pop_value = pop_value_reg;
    assign pop_disp  = pop_disp_reg;
endmodule

[rtl/lsm_controller.sv]
module lsm_controller #(
    parameter int MAX_STREAMS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      in_stream,
    input  logic [3:0]                      active_streams,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      refill_stream,
    output logic                            refill_wanted,
    output logic                            merge_done,
    output lsm_pkg::dp_cmd_t                cmd,
    output logic [$clog2(MAX_STREAMS)-1:0]  load_idx,
    output logic [$clog2(MAX_STREAMS)-1:0]  scan_idx,
    input  lsm_pkg::dp_status_t             status,
    input  logic [MAX_STREAMS-1:0]          present,
    input  logic [$clog2(MAX_STREAMS)-1:0]  best_idx
);
    localparam int IW  = $clog2(MAX_STREAMS);
    localparam int CAP = (MAX_STREAMS < lsm_pkg::RES_LIMIT) ? MAX_STREAMS
                                                            : lsm_pkg::RES_LIMIT;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_POP  = 5'b00100,
        S_OUT  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [IW-1:0] scan_reg;
    logic [3:0] seeded_reg;
    logic       pending_reg;
    logic [2:0] target_reg;
    logic       want_reg;
    logic       done_reg;
    logic       more_reg;   // pop again after this transfer
    logic [3:0] eff;
    logic       accept;
    logic       useful;
    logic       start;
    logic       in_range;
    logic       out_fire;

    always_comb
    begin
        eff = active_streams;
        if (eff == 4'd0)
            eff = 4'd1;
        if ({28'd0, eff} > 32'(CAP))
            eff = 4'(CAP);
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = ({29'd0, in_stream} < 32'(MAX_STREAMS))
                   && ({1'b0, in_stream} < eff);
    always_comb
    begin
        useful = 1'b0;
        start  = 1'b0;
        if (pending_reg)
        begin
            useful = (in_stream == target_reg);
            start  = useful;
        end
        else if (in_range && !present[IW'(in_stream)])
        begin
            useful = 1'b1;
            start  = (seeded_reg + 4'd1) >= eff;
        end
    end

    assign out_fire = out_valid && out_ready;
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept && start) state_next = S_SCAN;
            S_SCAN: if (scan_reg == IW'(MAX_STREAMS - 1)) state_next = S_POP;
            S_POP:  state_next = S_OUT;
            S_OUT:
                if (out_fire)
                begin
                    if (done_reg)
                        state_next = S_DONE;
                    else if (more_reg)
                        state_next = S_SCAN;
                    else
                        state_next = S_IDLE;
                end
            S_DONE: state_next = S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    assign cmd.load      = accept && useful;
    assign cmd.scan_clr  = (state_next == S_SCAN) && (state_reg != S_SCAN);
    assign cmd.scan_step = (state_reg == S_SCAN);
    assign cmd.pop       = (state_reg == S_POP);
    assign load_idx      = IW'(in_stream);
    assign scan_idx      = scan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            scan_reg    <= '0;
            seeded_reg  <= '0;
            pending_reg <= 1'b0;
            target_reg  <= '0;
            want_reg    <= 1'b0;
            done_reg    <= 1'b0;
            more_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SCAN)
                scan_reg <= scan_reg + IW'(1);
            else
                scan_reg <= '0;
            if (accept && useful)
            begin
                if (pending_reg)
                    pending_reg <= 1'b0;
                else
                    seeded_reg <= seeded_reg + 4'd1;
            end
            if (state_reg == S_POP)
            begin
                want_reg <= !status.best_last;
                done_reg <= status.best_last && !status.any_left;
                more_reg <= status.best_last && status.any_left;
                if (!status.best_last)
                begin
                    pending_reg <= 1'b1;
                    target_reg  <= 3'(best_idx);
                end
            end
        end
    end

    assign refill_wanted = want_reg;
    assign refill_stream = want_reg ? target_reg : 3'd0;
    assign merge_done    = done_reg;
endmodule

[rtl/lsm_merge_dedup_unit.sv]
// k-way merge and dedup for compaction
// input channel (in_valid/in_ready): one head entry per transfer, tagged with
// its stream; first one entry per active stream, then only the requested refill
// output channel (out_valid/out_ready): one popped entry per transfer with its
// disposition; refill_wanted on the last result of a step names the stream to
// send next, merge_done marks the final pop
// each pop scans the heads one per cycle through a single key comparator,
// then registers the best head into the output; a chained pop when a stream
// ends rescans the heads the same way
// an entry is taken only while no pop is in flight; a stalled receiver holds
// out_valid and the result, and the input stays blocked until the transfer
// reset clears all heads, the last-key valid flag and the seed count;
// configuration is active_streams (index 0) and the tombstone drop mode
// (index 1), to be written only while idle; the block does not enforce it.
// after merge_done the block accepts nothing until reset
module lsm_merge_dedup_unit #(
    parameter int MAX_STREAMS = 8,
    parameter int KEY_BITS    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  stream_index,
    input  logic [63:0] entry_key,
    input  logic [63:0] entry_value,
    input  logic        is_tombstone,
    input  logic        last_in_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_key,
    output logic [63:0] out_value,
    output logic [1:0]  disposition,
    output logic [2:0]  refill_stream,
    output logic        refill_wanted,
    output logic        merge_done
);
    localparam int IW = $clog2(MAX_STREAMS);

    logic [3:0]             active_reg;
    logic                   drop_reg;
    lsm_pkg::dp_cmd_t       cmd;
    lsm_pkg::dp_status_t    status;
    logic [MAX_STREAMS-1:0] present;
    logic [IW-1:0]          best_idx;
    logic [IW-1:0]          load_idx;
    logic [IW-1:0]          scan_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 4'd1;
            drop_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == lsm_pkg::CFG_ACTIVE_STREAMS)
                active_reg <= cfg_data;
            else
                drop_reg <= cfg_data[0];
        end
    end

    lsm_controller #(.MAX_STREAMS(MAX_STREAMS)) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_stream      (stream_index),
        .active_streams (active_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .refill_stream  (refill_stream),
        .refill_wanted  (refill_wanted),
        .merge_done     (merge_done),
        .cmd            (cmd),
        .load_idx       (load_idx),
        .scan_idx       (scan_idx),
        .status         (status),
        .present        (present),
        .best_idx       (best_idx)
    );

    lsm_datapath #(.MAX_STREAMS(MAX_STREAMS), .KEY_BITS(KEY_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .load_idx  (load_idx),
        .scan_idx  (scan_idx),
        .in_key    (entry_key),
        .in_value  (entry_value),
        .in_tomb   (is_tombstone),
        .in_last   (last_in_stream),
        .drop_tomb (drop_reg),
        .status    (status),
        .present   (present),
        .best_idx  (best_idx),
        .pop_key   (out_key),
        .pop_value (out_value),
        .pop_disp  (disposition)
    );
endmodule

[rtl/lsm_checker.sv]
module lsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_key,
    input logic [1:0]  disposition,
    input logic        refill_wanted,
    input logic        merge_done
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_key))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input open while a result waits");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(refill_wanted && merge_done) && disposition != 2'd3)
        else $error("bad result flags");

    a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && merge_done |=> !in_ready && !out_valid)
        else $error("activity after merge done");
endmodule

bind lsm_merge_dedup_unit lsm_checker u_lsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key       (out_key),
    .disposition   (disposition),
    .refill_wanted (refill_wanted),
    .merge_done    (merge_done)
);
